[hw/rtl/softened_pairwise_gravity_force_top_macros.svh]
// ---------------------------------------------------------------------------
// softened pairwise gravity force - assertion macros
// shared property shapes for the checker
// ---------------------------------------------------------------------------
`ifndef SOFTENED_PAIRWISE_GRAVITY_FORCE_TOP_MACROS_SVH
`define SOFTENED_PAIRWISE_GRAVITY_FORCE_TOP_MACROS_SVH

// same-cycle implication
`define SGF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgf assertion failed");

// next-cycle implication
`define SGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgf assertion failed");

`endif

[hw/rtl/sgf_pkg.sv]
// ---------------------------------------------------------------------------
// sgf_pkg
// beat types and fixed constants of the softened gravity force block
// ---------------------------------------------------------------------------
package sgf_pkg;

    localparam int POS_W   = 24;
    localparam int MASS_W  = 16;
    localparam int GRAV_W  = 32;
    localparam int FORCE_W = 48;
    localparam int G_FRAC  = 24;

    localparam logic [GRAV_W-1:0]  G_RESET   = 32'd16777216;
    localparam logic [FORCE_W-1:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic [MASS_W-1:0]       own_mass;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic [MASS_W-1:0]       other_mass;
    } in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      saturated;
    } out_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic sat_x;
        logic sat_y;
    } flags_t;

endpackage

[hw/rtl/sgf_isqrt.sv]
// ---------------------------------------------------------------------------
// sgf_isqrt
// pipelined integer square root, one result bit per stage, with sideband
// ---------------------------------------------------------------------------
module sgf_isqrt #(
    parameter int ROOT_W = 25,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RAD_W = 2 * ROOT_W;

    logic              vld_s  [ROOT_W+1];
    logic [RAD_W-1:0]  rem_s  [ROOT_W+1];
    logic [ROOT_W-1:0] root_s [ROOT_W+1];
    logic [SIDE_W-1:0] side_s [ROOT_W+1];

    assign vld_s[0]  = in_valid;
    assign rem_s[0]  = in_radicand;
    assign root_s[0] = '0;
    assign side_s[0] = in_side;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - j;

        logic [RAD_W:0]    trial;
        logic              take;
        logic              vld_reg;
        logic [RAD_W-1:0]  rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SIDE_W-1:0] side_reg;

        always_comb
        begin
            trial = ({1'b0, {ROOT_W{1'b0}}, root_s[j]} << (B + 1))
                  + ((RAD_W+1)'(1) << (2 * B));
            take  = {1'b0, rem_s[j]} >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= take ? RAD_W'({1'b0, rem_s[j]} - trial) : rem_s[j];
                root_reg <= take ? (root_s[j] | (ROOT_W'(1) << B)) : root_s[j];
                side_reg <= side_s[j];
            end
        end

        assign vld_s[j+1]  = vld_reg;
        assign rem_s[j+1]  = rem_reg;
        assign root_s[j+1] = root_reg;
        assign side_s[j+1] = side_reg;
    end

    assign out_valid = vld_s[ROOT_W];
    assign out_root  = root_s[ROOT_W];
    assign out_side  = side_s[ROOT_W];

endmodule

[hw/rtl/sgf_div_pipe.sv]
// ---------------------------------------------------------------------------
// sgf_div_pipe
// pipelined restoring divider for both components over a shared divisor
// ---------------------------------------------------------------------------
module sgf_div_pipe #(
    parameter int NUM_W  = 89,
    parameter int DEN_W  = 78,
    parameter int Q_W    = 48,
    parameter int SIDE_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num_x,
    input  logic [NUM_W-1:0]  in_num_y,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_q_x,
    output logic [Q_W-1:0]    out_q_y,
    output logic [SIDE_W-1:0] out_side
);

    localparam int R_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              vld_s  [Q_W+1];
    logic [R_W-1:0]    rx_s   [Q_W+1];
    logic [R_W-1:0]    ry_s   [Q_W+1];
    logic [DEN_W-1:0]  den_s  [Q_W+1];
    logic [Q_W-1:0]    qx_s   [Q_W+1];
    logic [Q_W-1:0]    qy_s   [Q_W+1];
    logic [SIDE_W-1:0] side_s [Q_W+1];

    assign vld_s[0]  = in_valid;
    assign rx_s[0]   = R_W'(in_num_x);
    assign ry_s[0]   = R_W'(in_num_y);
    assign den_s[0]  = in_den;
    assign qx_s[0]   = '0;
    assign qy_s[0]   = '0;
    assign side_s[0] = in_side;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_stage
        localparam int B = Q_W - 1 - j;

        logic [R_W-1:0]    dsh;
        logic              take_x;
        logic              take_y;
        logic              vld_reg;
        logic [R_W-1:0]    rx_reg;
        logic [R_W-1:0]    ry_reg;
        logic [DEN_W-1:0]  den_reg;
        logic [Q_W-1:0]    qx_reg;
        logic [Q_W-1:0]    qy_reg;
        logic [SIDE_W-1:0] side_reg;

        always_comb
        begin
            dsh    = R_W'(den_s[j]) << B;
            take_x = rx_s[j] >= dsh;
            take_y = ry_s[j] >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg   <= take_x ? rx_s[j] - dsh : rx_s[j];
                ry_reg   <= take_y ? ry_s[j] - dsh : ry_s[j];
                den_reg  <= den_s[j];
                qx_reg   <= {qx_s[j][Q_W-2:0], take_x};
                qy_reg   <= {qy_s[j][Q_W-2:0], take_y};
                side_reg <= side_s[j];
            end
        end

        assign vld_s[j+1]  = vld_reg;
        assign rx_s[j+1]   = rx_reg;
        assign ry_s[j+1]   = ry_reg;
        assign den_s[j+1]  = den_reg;
        assign qx_s[j+1]   = qx_reg;
        assign qy_s[j+1]   = qy_reg;
        assign side_s[j+1] = side_reg;
    end

    assign out_valid = vld_s[Q_W];
    assign out_q_x   = qx_s[Q_W];
    assign out_q_y   = qy_s[Q_W];
    assign out_side  = side_s[Q_W];

endmodule

[hw/rtl/softened_pairwise_gravity_force_top.sv]
// ---------------------------------------------------------------------------
// softened_pairwise_gravity_force_top
// 2d force on one body from another, softened inverse square, saturated
// ---------------------------------------------------------------------------
// channel | direction | handshake           | beat
// in      | in        | in_valid / in_stall | in_t, one body pair
// out     | out       | out_valid/out_stall | out_t, force and clip flag
// cfg     | in        | cfg_valid/cfg_ready | gravity constant, 32 bits
//
// one pair per cycle while in_stall is low; in_stall rises when the output buffer is full
// a pair runs through the front stages, the 25 root stages, the cube stages and the 48 quotient stages
// a two-beat output buffer lets the pipe keep moving while one result waits
// rst_n clears all valid bits and loads the gravity constant with 1.0
// ---------------------------------------------------------------------------
module softened_pairwise_gravity_force_top
    import sgf_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GRAV_W-1:0] cfg_data
);

    localparam int SOFT    = ((1 << FRACTION_BITS) + 5) / 10;
    localparam int NUM_SH  = (3 * FRACTION_BITS >= G_FRAC) ? 3 * FRACTION_BITS - G_FRAC : 0;
    localparam int DEN_SH  = (3 * FRACTION_BITS < G_FRAC) ? G_FRAC - 3 * FRACTION_BITS : 0;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int ROOT_W  = DIFF_W;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int S_W     = ROOT_W + 1;
    localparam int SS_W    = 2 * S_W;
    localparam int GM_W    = GRAV_W + MASS_W;
    localparam int K_W     = GRAV_W + 2 * MASS_W;
    localparam int K_H     = K_W / 2;
    localparam int PP_W    = DIFF_W + K_H;
    localparam int NP_W    = DIFF_W + K_W;
    localparam int D0_W    = 3 * S_W;
    localparam int NUM_W   = NP_W + NUM_SH;
    localparam int DEN_W   = D0_W + DEN_SH;
    localparam int R_W     = (NUM_W > DEN_W + FORCE_W) ? NUM_W : DEN_W + FORCE_W;
    localparam int SIDE_W  = 2 * DIFF_W + K_W;

    // gravity constant
    logic [GRAV_W-1:0] g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_reg <= G_RESET;
        else if (cfg_valid)
            g_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // pipe enable from the output buffer fill
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       en;

    assign en       = (cnt_reg != 2'd2);
    assign in_stall = !en;

    // front stages
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic [GM_W-1:0]          gm1_reg;
    logic [MASS_W-1:0]        m2_1_reg;
    logic [SQ_W-1:0]          sqx2_reg, sqy2_reg;
    logic [K_W-1:0]           k2_reg, k3_reg;
    logic [RAD_W-1:0]         rad3_reg;
    logic signed [2*DIFF_W-1:0] px, py;

    assign px = dx1_reg * dx1_reg;
    assign py = dy1_reg * dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= DIFF_W'(in_data.other_x) - DIFF_W'(in_data.own_x);
            dy1_reg  <= DIFF_W'(in_data.other_y) - DIFF_W'(in_data.own_y);
            gm1_reg  <= GM_W'(g_reg) * GM_W'(in_data.own_mass);
            m2_1_reg <= in_data.other_mass;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            sqx2_reg <= px[SQ_W-1:0];
            sqy2_reg <= py[SQ_W-1:0];
            k2_reg   <= K_W'(gm1_reg) * K_W'(m2_1_reg);
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            k3_reg   <= k2_reg;
            rad3_reg <= RAD_W'(sqx2_reg) + RAD_W'(sqy2_reg);
        end
    end

    // distance
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    sgf_isqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v3_reg),
        .in_radicand (rad3_reg),
        .in_side     ({dx3_reg, dy3_reg, k3_reg}),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_side    (sq_side)
    );

    logic signed [DIFF_W-1:0] dxq, dyq;
    logic [K_W-1:0]           kq;

    assign dxq = sq_side[SIDE_W-1 -: DIFF_W];
    assign dyq = sq_side[K_W +: DIFF_W];
    assign kq  = sq_side[K_W-1:0];

    // cube and numerators
    logic                v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [S_W-1:0]      s4_reg, s5_reg;
    logic [DIFF_W-1:0]   ax4_reg, ay4_reg;
    logic [K_W-1:0]      k4_reg;
    logic [SS_W-1:0]     ss5_reg, dl6_reg, dh6_reg;
    logic [PP_W-1:0]     nxl5_reg, nxh5_reg, nyl5_reg, nyh5_reg;
    logic [NP_W-1:0]     numx6_reg, numy6_reg;
    logic [NUM_W-1:0]    numx7_reg, numy7_reg, numx8_reg, numy8_reg;
    logic [DEN_W-1:0]    den7_reg, den8_reg;
    flags_t              f4_reg, f5_reg, f6_reg, f7_reg, f8_reg;
    logic [D0_W-1:0]     den_raw;
    logic [R_W-1:0]      den_top;

    assign den_raw = {dh6_reg, {S_W{1'b0}}} + D0_W'(dl6_reg);
    assign den_top = R_W'(den7_reg) << FORCE_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= sq_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg       <= S_W'(sq_root) + S_W'(SOFT);
            ax4_reg      <= dxq[DIFF_W-1] ? DIFF_W'(-dxq) : DIFF_W'(dxq);
            ay4_reg      <= dyq[DIFF_W-1] ? DIFF_W'(-dyq) : DIFF_W'(dyq);
            k4_reg       <= kq;
            f4_reg.neg_x <= dxq[DIFF_W-1];
            f4_reg.neg_y <= dyq[DIFF_W-1];
            f4_reg.sat_x <= 1'b0;
            f4_reg.sat_y <= 1'b0;

            s5_reg   <= s4_reg;
            ss5_reg  <= SS_W'(s4_reg) * SS_W'(s4_reg);
            nxl5_reg <= PP_W'(ax4_reg) * PP_W'(k4_reg[K_H-1:0]);
            nxh5_reg <= PP_W'(ax4_reg) * PP_W'(k4_reg[K_W-1:K_H]);
            nyl5_reg <= PP_W'(ay4_reg) * PP_W'(k4_reg[K_H-1:0]);
            nyh5_reg <= PP_W'(ay4_reg) * PP_W'(k4_reg[K_W-1:K_H]);
            f5_reg   <= f4_reg;

            dl6_reg   <= SS_W'(ss5_reg[S_W-1:0]) * SS_W'(s5_reg);
            dh6_reg   <= SS_W'(ss5_reg[SS_W-1:S_W]) * SS_W'(s5_reg);
            numx6_reg <= {nxh5_reg, {K_H{1'b0}}} + NP_W'(nxl5_reg);
            numy6_reg <= {nyh5_reg, {K_H{1'b0}}} + NP_W'(nyl5_reg);
            f6_reg    <= f5_reg;

            den7_reg  <= DEN_W'(den_raw) << DEN_SH;
            numx7_reg <= NUM_W'(numx6_reg) << NUM_SH;
            numy7_reg <= NUM_W'(numy6_reg) << NUM_SH;
            f7_reg    <= f6_reg;

            den8_reg     <= den7_reg;
            numx8_reg    <= numx7_reg;
            numy8_reg    <= numy7_reg;
            f8_reg.neg_x <= f7_reg.neg_x;
            f8_reg.neg_y <= f7_reg.neg_y;
            f8_reg.sat_x <= R_W'(numx7_reg) >= den_top;
            f8_reg.sat_y <= R_W'(numy7_reg) >= den_top;
        end
    end

    // quotients
    logic               dv_valid;
    logic [FORCE_W-1:0] qx, qy;
    logic [3:0]         dv_side;
    flags_t             fq;

    sgf_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (FORCE_W),
        .SIDE_W ($bits(flags_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .in_num_x  (numx8_reg),
        .in_num_y  (numy8_reg),
        .in_den    (den8_reg),
        .in_side   (f8_reg),
        .out_valid (dv_valid),
        .out_q_x   (qx),
        .out_q_y   (qy),
        .out_side  (dv_side)
    );

    assign fq = flags_t'(dv_side);

    // clip and sign
    logic [FORCE_W-1:0] lim_x, lim_y, mag_x, mag_y;
    logic               clip_x, clip_y;
    out_t               res;

    always_comb
    begin
        lim_x         = fq.neg_x ? FORCE_MIN : FORCE_MAX;
        lim_y         = fq.neg_y ? FORCE_MIN : FORCE_MAX;
        clip_x        = fq.sat_x || (qx > lim_x);
        clip_y        = fq.sat_y || (qy > lim_y);
        mag_x         = clip_x ? lim_x : qx;
        mag_y         = clip_y ? lim_y : qy;
        res.force_x   = fq.neg_x ? -mag_x : mag_x;
        res.force_y   = fq.neg_y ? -mag_y : mag_y;
        res.saturated = clip_x || clip_y;
    end

    // output buffer, two beats
    out_t ent0_reg, ent1_reg, ent0_next, ent1_next;
    logic push, pop;

    assign push = dv_valid && en;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        cnt_next  = cnt_reg;
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        if (push && pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                ent0_next = ent1_reg;
                ent1_next = res;
            end
            else
                ent0_next = res;
        end
        else if (pop)
        begin
            ent0_next = ent1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                ent0_next = res;
            else
                ent1_next = res;
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = ent0_reg;

endmodule

[hw/rtl/sgf_checker.sv]
// ---------------------------------------------------------------------------
// sgf_checker
// port-level checks on the softened gravity force block
// ---------------------------------------------------------------------------
`include "softened_pairwise_gravity_force_top_macros.svh"

module sgf_checker
    import sgf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    logic clip_seen;

    assign clip_seen = (out_data.force_x == FORCE_MAX) || (out_data.force_x == FORCE_MIN)
                    || (out_data.force_y == FORCE_MAX) || (out_data.force_y == FORCE_MIN);

    `SGF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `SGF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
    `SGF_ASSERT_IMPLY(a_sat_at_limit, clk, rst_n, out_valid && out_data.saturated, clip_seen)
    `SGF_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, $past(out_valid && out_stall))

endmodule

bind softened_pairwise_gravity_force_top sgf_checker u_sgf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/sv/softened_pairwise_gravity_force_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// softened_pairwise_gravity_force_top_tb
// Self-checking testbench for the softened pairwise gravity force block.
// Body pairs are driven through the valid/stall input channel. Each accepted
// pair is run through a local bit-exact force predictor, and the predicted
// force is queued. Every beat leaving the output is compared field by field
// with the oldest queued force. Both sides of the block see random idling.
// Directed pairs cover the extremes, coincident bodies, zero masses and
// saturation. Random pairs then run under several gravity constants,
// including the all-ones one, and one long output hold fills the pipeline.
// ---------------------------------------------------------------------------
module softened_pairwise_gravity_force_top_tb;
    import sgf_pkg::*;

    localparam int FRAC       = 8;
    localparam int SOFT       = ((1 << FRAC) + 5) / 10;
    localparam int DRAIN_WAIT = 100;
    localparam int WATCHDOG   = 5000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_t               in_data;
    logic              out_valid;
    logic              out_stall;
    out_t              out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GRAV_W-1:0] cfg_data;

    logic [GRAV_W-1:0] gravity;
    out_t              pending_forces[$];
    int                mismatches;
    int                idle_cycles;
    int                stall_mode;
    bit                hold_request;

    softened_pairwise_gravity_force_top #(.FRACTION_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [FORCE_W-1:0] force_component(logic [24:0] diff,
            logic [63:0] k, logic [127:0] den, inout logic sat);
        logic              neg;
        logic [24:0]       mag;
        logic [127:0]      num;
        logic [127:0]      q;
        logic [FORCE_W-1:0] lim;
        neg = diff[24];
        mag = neg ? -diff : diff;
        lim = neg ? FORCE_MIN : FORCE_MAX;
        num = 128'(mag) * 128'(k);
        if (3 * FRAC >= G_FRAC)
            num = num << (3 * FRAC - G_FRAC);
        q = num / den;
        if (q > 128'(lim))
        begin
            q = 128'(lim);
            sat = 1'b1;
        end
        return neg ? -q[FORCE_W-1:0] : q[FORCE_W-1:0];
    endfunction

    function automatic out_t predict_force(in_t p, logic [GRAV_W-1:0] g);
        logic [24:0]  dx;
        logic [24:0]  dy;
        logic [24:0]  ax;
        logic [24:0]  ay;
        logic [63:0]  s;
        logic [63:0]  k;
        logic [127:0] den;
        logic         sat;
        out_t         r;
        dx  = {p.other_x[POS_W-1], p.other_x} - {p.own_x[POS_W-1], p.own_x};
        dy  = {p.other_y[POS_W-1], p.other_y} - {p.own_y[POS_W-1], p.own_y};
        ax  = dx[24] ? -dx : dx;
        ay  = dy[24] ? -dy : dy;
        s   = int_sqrt(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay)) + SOFT;
        k   = 64'(g) * 64'(p.own_mass) * 64'(p.other_mass);
        den = 128'(s * s) * 128'(s);
        if (3 * FRAC < G_FRAC)
            den = den << (G_FRAC - 3 * FRAC);
        sat = 1'b0;
        r.force_x   = force_component(dx, k, den, sat);
        r.force_y   = force_component(dy, k, den, sat);
        r.saturated = sat;
        return r;
    endfunction

    // output side: stall pattern and the long hold
    initial
    begin
        int hold_count;
        int phase;
        out_stall  = 1'b0;
        hold_count = 0;
        phase      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_count == 0)
            begin
                hold_count   = 400;
                hold_request = 1'b0;
            end
            if (hold_count > 0)
            begin
                hold_count = hold_count - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                phase = phase + 1;
                if (phase % 64 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= (phase % 8 < 5);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_t exp_f;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", out_data);
            end
            else
            begin
                exp_f = pending_forces.pop_front();
                if (out_data.force_x !== exp_f.force_x
                        || out_data.force_y !== exp_f.force_y
                        || out_data.saturated !== exp_f.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch: exp x=%h y=%h sat=%b got x=%h y=%h sat=%b",
                                 exp_f.force_x, exp_f.force_y, exp_f.saturated,
                                 out_data.force_x, out_data.force_y, out_data.saturated);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pair(in_t p);
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        pending_forces.insert(pending_forces.size(), predict_force(p, gravity));
    endtask

    task automatic input_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_gravity(logic [GRAV_W-1:0] g);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gravity = g;
    endtask

    function automatic in_t make_pair(int a, int b, int m1, int c, int d, int m2);
        in_t p;
        p.own_x      = POS_W'(a);
        p.own_y      = POS_W'(b);
        p.own_mass   = MASS_W'(m1);
        p.other_x    = POS_W'(c);
        p.other_y    = POS_W'(d);
        p.other_mass = MASS_W'(m2);
        return p;
    endfunction

    function automatic in_t random_pair();
        in_t p;
        p = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0:
            begin
                p.other_x = p.own_x + $signed(24'($urandom_range(0, 2047)) - 24'd1024);
                p.other_y = p.own_y + $signed(24'($urandom_range(0, 2047)) - 24'd1024);
            end
            1:
            begin
                p.other_x = p.own_x + $signed(24'($urandom_range(0, 15)) - 24'd8);
                p.other_y = p.own_y + $signed(24'($urandom_range(0, 15)) - 24'd8);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        send_pair(make_pair(0, 0, 1, 0, 0, 1));
        send_pair(make_pair(1000, -2000, 65535, 1000, -2000, 65535));
        send_pair(make_pair(0, 0, 0, 256, 256, 100));
        send_pair(make_pair(0, 0, 100, 256, 256, 0));
        send_pair(make_pair(0, 0, 1, 256, 0, 1));
        send_pair(make_pair(0, 0, 1, 0, -256, 1));
        send_pair(make_pair(-8388608, -8388608, 65535, 8388607, 8388607, 65535));
        send_pair(make_pair(8388607, 8388607, 65535, -8388608, -8388608, 65535));
        send_pair(make_pair(8388607, -8388608, 1, -8388608, 8388607, 1));
        send_pair(make_pair(0, 0, 65535, 1, 0, 65535));
        send_pair(make_pair(0, 0, 65535, -1, -1, 65535));
        send_pair(make_pair(0, 0, 65535, 26, -26, 65535));
        send_pair(make_pair(5, 5, 65535, 5, 6, 65535));
        input_gap(3);
        send_pair(make_pair(-3, 7, 2, 7, -3, 3));
    endtask

    task automatic test_gravity_extremes();
        write_gravity('0);
        send_pair(make_pair(0, 0, 65535, 100, 100, 65535));
        send_pair(make_pair(0, 0, 65535, 1, 1, 65535));
        write_gravity('1);
        send_pair(make_pair(0, 0, 65535, 1, 0, 65535));
        send_pair(make_pair(0, 0, 65535, 0, -1, 65535));
        send_pair(make_pair(0, 0, 1, 8388607, 0, 1));
        send_pair(make_pair(0, 0, 2, 3, 4, 2));
        send_pair(make_pair(-8388608, 0, 65535, 8388607, 1, 65535));
    endtask

    task automatic test_random(int count);
        int burst;
        burst = $urandom_range(1, 30);
        repeat (count)
        begin
            send_pair(random_pair());
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    input_gap($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (250) send_pair(random_pair());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        gravity      = G_RESET;
        mismatches   = 0;
        idle_cycles  = 0;
        stall_mode   = 0;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_gravity_extremes();
        write_gravity(G_RESET);
        test_random(300);
        write_gravity($urandom);
        test_random(200);
        write_gravity(32'd1 << $urandom_range(0, 31));
        test_random(200);
        write_gravity('1);
        test_random(150);
        write_gravity($urandom_range(1, 255));
        test_backpressure();

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sgf_pkg.sv
hw/rtl/sgf_isqrt.sv
hw/rtl/sgf_div_pipe.sv
hw/rtl/softened_pairwise_gravity_force_top.sv
hw/rtl/sgf_checker.sv
tb/sv/softened_pairwise_gravity_force_top_tb.sv
